// ===== rtl/rhpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rhpm_pkg: shared types and constants
// Modes, result kinds, status codes and controller commands for the matcher.
// ----------------------------------------------------------------------------
package rhpm_pkg;

  localparam int PatternMax   = 64;
  localparam int PtrBits      = $clog2(PatternMax);
  localparam int LenBits      = $clog2(PatternMax + 1);
  localparam int PositionBits = 32;
  localparam int PosBits      = (PositionBits < 32) ? PositionBits : 32;
  localparam int HashBits     = 31;
  localparam logic [HashBits-1:0] HashMod  = 31'h7FFF_FFFF;
  localparam logic [6:0]          HashBase = 7'd101;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_PAT   = 2'd1,
    MODE_TEXT  = 2'd2,
    MODE_END   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_MATCH   = 2'd0,
    KIND_COLLIDE = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_LONGER   = 2'd2,
    ST_OVERFLOW = 2'd3
  } result_status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_PAT, S_TEXT1, S_TEXT2, S_TEXT3, S_CHECK,
    S_CMP, S_CMPWAIT, S_EMIT, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;       // start of job
    logic pat_load;    // store pattern byte, update hash and power
    logic pat_ovf;     // set overflow
    logic text_count;  // bump text counter
    logic text_mul;    // first hash step: products
    logic text_sum;    // second step: reduce
    logic text_fin;    // third step: combine, store byte
    logic cmp_start;   // reset compare index
    logic cmp_step;    // compare one byte pair
    logic cmp_done;    // bump match count on a full match
    logic emit_hit;    // load hit result into output
    logic emit_sum;    // load summary result into output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic can_pat;     // text_count is zero
    logic pat_full;
    logic text_room;   // below position limit
    logic active;      // pattern non-empty and no overflow
    logic hit;         // full window and hashes equal
    logic cmp_last;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/rhpm_datapath.sv =====
// ----------------------------------------------------------------------------
// rhpm_datapath: hash arithmetic, byte stores, counters, output register
// Mersenne reduction over registered steps; byte compare one pair at a time.
// ----------------------------------------------------------------------------
module rhpm_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  rhpm_pkg::cmd_t        cmd,
  output rhpm_pkg::stat_t       stat,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [31:0]           out_position,
  output logic [31:0]           out_total,
  output logic [1:0]            out_status
);

  localparam int HB = rhpm_pkg::HashBits;
  localparam int PB = rhpm_pkg::PtrBits;
  localparam int LB = rhpm_pkg::LenBits;
  localparam logic [31:0] PosLimit = (rhpm_pkg::PosBits >= 32) ? 32'hFFFF_FFFF
                                   : 32'((64'd1 << rhpm_pkg::PosBits) - 64'd1);

  logic [7:0]    pattern_store [rhpm_pkg::PatternMax];
  logic [7:0]    window_store  [rhpm_pkg::PatternMax];
  logic [LB-1:0] pattern_length;
  logic          pattern_overflow;
  logic [HB-1:0] pattern_hash, drop_power, window_hash;
  logic [31:0]   text_count, match_count;
  logic [PB-1:0] slot;        // old % len, kept incrementally
  logic [PB-1:0] cmp_idx, win_idx;
  logic [37:0]   prod_a;      // window_hash*101 + byte
  logic [38:0]   prod_b;      // leaving*drop_power
  logic [HB-1:0] red_a, red_b;
  logic [7:0]    pat_rd, win_rd, leave_rd;
  logic          cmp_eq;
  logic          same;

  // fold of 2^31-1: x mod M for x below 2^39
  function automatic logic [HB-1:0] fold(input logic [38:0] x);
    logic [31:0] s;
    logic [HB-1:0] r;
    begin
      s = {1'b0, x[30:0]} + {24'd0, x[38:31]};
      r = s[30:0] + {30'd0, s[31]};
      if (r == rhpm_pkg::HashMod) r = '0;
      fold = r;
    end
  endfunction

  logic [LB-1:0] len_m1;
  assign len_m1 = pattern_length - LB'(1);

  always_ff @(posedge clk) begin
    if (cmd.pat_load) pattern_store[pattern_length[PB-1:0]] <= in_byte;
    if (cmd.text_fin) window_store[slot] <= in_byte;
    pat_rd   <= pattern_store[cmp_idx];
    win_rd   <= window_store[win_idx];
    leave_rd <= window_store[slot];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pattern_length   <= '0;
      pattern_overflow <= 1'b0;
      pattern_hash     <= '0;
      drop_power       <= HB'(1);
      window_hash      <= '0;
      text_count       <= '0;
      match_count      <= '0;
      slot             <= '0;
      cmp_idx          <= '0;
      win_idx          <= '0;
      same             <= 1'b0;
    end else begin
      if (cmd.pat_load) begin
        pattern_length <= pattern_length + LB'(1);
        pattern_hash   <= fold({1'b0, 38'(pattern_hash) * 38'(rhpm_pkg::HashBase)
                                + 38'(in_byte)});
        drop_power     <= fold({1'b0, 38'(drop_power) * 38'(rhpm_pkg::HashBase)});
      end
      if (cmd.pat_ovf) pattern_overflow <= 1'b1;
      if (cmd.text_count) text_count <= text_count + 32'd1;
      if (cmd.text_mul) begin
        prod_a <= 38'(window_hash) * 38'(rhpm_pkg::HashBase) + 38'(in_byte);
        prod_b <= (text_count > {{(32-LB){1'b0}}, pattern_length})
                  ? 39'(leave_rd) * 39'(drop_power) : '0;
      end
      if (cmd.text_sum) begin
        red_a <= fold({1'b0, prod_a});
        red_b <= fold(prod_b);
      end
      if (cmd.text_fin) begin
        window_hash <= (red_a >= red_b) ? red_a - red_b
                     : HB'(32'(red_a) + 32'(rhpm_pkg::HashMod) - 32'(red_b));
        slot <= (32'(slot) == 32'(len_m1)) ? '0 : slot + PB'(1);
      end
      if (cmd.cmp_start) begin
        cmp_idx <= '0;
        win_idx <= slot;   // oldest byte sits at the next write slot
        same    <= 1'b1;
      end
      if (cmd.cmp_step) begin
        cmp_idx <= cmp_idx + PB'(1);
        win_idx <= (32'(win_idx) == 32'(len_m1)) ? '0 : win_idx + PB'(1);
      end
      if (cmd.cmp_done && same && match_count != 32'hFFFF_FFFF)
        match_count <= match_count + 32'd1;
      if (cmd.cmp_step && !cmp_eq) same <= 1'b0;
    end
  end

  // compare uses registered read data of the previous address
  assign cmp_eq = (pat_rd == win_rd);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit_hit || cmd.emit_sum) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit) begin
      out_kind     <= same ? rhpm_pkg::KIND_MATCH : rhpm_pkg::KIND_COLLIDE;
      out_position <= text_count - 32'(pattern_length);
      out_total    <= match_count;
      out_status   <= rhpm_pkg::ST_OK;
    end else if (cmd.emit_sum) begin
      out_kind     <= rhpm_pkg::KIND_SUMMARY;
      out_position <= '0;
      out_total    <= match_count;
      if (pattern_overflow) out_status <= rhpm_pkg::ST_OVERFLOW;
      else if (32'(pattern_length) > text_count) out_status <= rhpm_pkg::ST_LONGER;
      else if (match_count == '0) out_status <= rhpm_pkg::ST_NOTFOUND;
      else out_status <= rhpm_pkg::ST_OK;
    end
  end

  assign stat.can_pat   = (text_count == '0);
  assign stat.pat_full  = (32'(pattern_length) >= 32'(rhpm_pkg::PatternMax));
  assign stat.text_room = (text_count < PosLimit);
  assign stat.active    = (pattern_length != '0) && !pattern_overflow;
  assign stat.hit       = (text_count >= 32'(pattern_length)) && (window_hash == pattern_hash);
  assign stat.cmp_last  = (32'(cmp_idx) == 32'(len_m1));
  assign stat.out_busy  = out_valid && !out_ready;

  property p_pow_nonzero;
    @(posedge clk) disable iff (rst) drop_power != '0;
  endproperty
  a_pow_nonzero: assert property (p_pow_nonzero) else $error("drop power zero");

  property p_hash_range;
    @(posedge clk) disable iff (rst) window_hash != rhpm_pkg::HashMod;
  endproperty
  a_hash_range: assert property (p_hash_range) else $error("hash not reduced");

  property p_len_range;
    @(posedge clk) disable iff (rst) 32'(pattern_length) <= 32'(rhpm_pkg::PatternMax);
  endproperty
  a_len_range: assert property (p_len_range) else $error("length out of range");

endmodule

// ===== rtl/rhpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rhpm_ctrl: sequencing state machine
// Takes one word, steps the datapath through the hash and compare phases.
// ----------------------------------------------------------------------------
module rhpm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_mode,
  output rhpm_pkg::cmd_t  cmd,
  input  rhpm_pkg::stat_t stat
);

  rhpm_pkg::state_t state, state_next;
  logic [1:0] mode;

  always_ff @(posedge clk) begin
    if (rst) state <= rhpm_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mode <= in_mode;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      rhpm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = rhpm_pkg::S_DECODE;
      end
      rhpm_pkg::S_DECODE: begin
        unique case (rhpm_pkg::mode_t'(mode))
          rhpm_pkg::MODE_START: begin
            cmd.clear = 1'b1;
            state_next = rhpm_pkg::S_IDLE;
          end
          rhpm_pkg::MODE_PAT: begin
            if (stat.can_pat && stat.pat_full) cmd.pat_ovf = 1'b1;
            else if (stat.can_pat) cmd.pat_load = 1'b1;
            state_next = rhpm_pkg::S_IDLE;
          end
          rhpm_pkg::MODE_TEXT: begin
            if (!stat.text_room) state_next = rhpm_pkg::S_IDLE;
            else begin
              cmd.text_count = 1'b1;
              state_next = stat.active ? rhpm_pkg::S_TEXT1 : rhpm_pkg::S_IDLE;
            end
          end
          rhpm_pkg::MODE_END: state_next = rhpm_pkg::S_OUT;
          default: state_next = rhpm_pkg::S_IDLE;
        endcase
      end
      rhpm_pkg::S_TEXT1: begin cmd.text_mul = 1'b1; state_next = rhpm_pkg::S_TEXT2; end
      rhpm_pkg::S_TEXT2: begin cmd.text_sum = 1'b1; state_next = rhpm_pkg::S_TEXT3; end
      rhpm_pkg::S_TEXT3: begin cmd.text_fin = 1'b1; state_next = rhpm_pkg::S_CHECK; end
      rhpm_pkg::S_CHECK: begin
        if (stat.hit) begin
          cmd.cmp_start = 1'b1;
          state_next = rhpm_pkg::S_CMPWAIT;
        end else state_next = rhpm_pkg::S_IDLE;
      end
      rhpm_pkg::S_CMPWAIT: state_next = rhpm_pkg::S_CMP;  // read latency
      rhpm_pkg::S_CMP: begin
        cmd.cmp_step = 1'b1;
        state_next = stat.cmp_last ? rhpm_pkg::S_EMIT : rhpm_pkg::S_CMPWAIT;
      end
      rhpm_pkg::S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.cmp_done = 1'b1;
          state_next = rhpm_pkg::S_OUT;
        end
      end
      rhpm_pkg::S_OUT: begin
        if (!stat.out_busy) begin
          if (mode == rhpm_pkg::MODE_END) cmd.emit_sum = 1'b1;
          else cmd.emit_hit = 1'b1;
          state_next = rhpm_pkg::S_IDLE;
        end
      end
      default: state_next = rhpm_pkg::S_IDLE;
    endcase
  end

  property p_ready_idle;
    @(posedge clk) disable iff (rst) in_ready |-> state == rhpm_pkg::S_IDLE;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

  property p_emit_once;
    @(posedge clk) disable iff (rst) !(cmd.emit_hit && cmd.emit_sum);
  endproperty
  a_emit_once: assert property (p_emit_once) else $error("double emit");

  property p_text_seq;
    @(posedge clk) disable iff (rst) cmd.text_mul |=> cmd.text_sum;
  endproperty
  a_text_seq: assert property (p_text_seq) else $error("hash sequence broken");

endmodule

// ===== rtl/rolling_hash_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher: rolling-hash string matcher
// Start, pattern and text words in; match, collision and summary words out.
// A new word is accepted only in idle, once the last one is fully handled:
// start and pattern words are decoded; text words with a live pattern run
// the multiply, reduce and combine steps and a hash check; on a hash hit
// the bytes are compared pair by pair before a result word; end-of-text
// emits the summary. Output stalls hold the emit states.
// Reset: rst clears the job state; byte stores hold garbage until written.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] position, [63:32] match_total,
                                 // [65:64] status_code
  output logic [1:0]  m_tuser    // [1:0] kind
);

  rhpm_pkg::cmd_t  cmd;
  rhpm_pkg::stat_t stat;
  logic [7:0]  in_byte;
  logic [1:0]  kind, status_code;
  logic [31:0] position, match_total;

  // byte is captured along with the mode so later states see it
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
  end

  rhpm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_mode (s_tuser),
    .cmd     (cmd),
    .stat    (stat)
  );

  rhpm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_byte     (in_byte),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (kind),
    .out_position(position),
    .out_total   (match_total),
    .out_status  (status_code)
  );

  assign m_tdata = {6'd0, status_code, match_total, position};
  assign m_tuser = kind;

endmodule
